// ===== hdl/slm_pkg.sv =====
// Shared types and codes for the sorted list merge block.
// No dependencies; imported by the merge top level.
`timescale 1ns / 1ps

package slm_pkg;

   // Item field widths
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned ACTION_W = 2;

   typedef logic [ACTION_W-1:0]        action_type;
   typedef logic signed [VALUE_W-1:0]  value_type;

   // Action codes (code 3 is unused and ignored)
   localparam action_type ACT_APPEND_FIRST  = 2'd0;
   localparam action_type ACT_APPEND_SECOND = 2'd1;
   localparam action_type ACT_MERGE         = 2'd2;

   // Controller states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

endpackage

// ===== hdl/slm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for both list stores of the merge block.
`timescale 1ns / 1ps

module slm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sorted_list_merge_top.sv =====
// Top level of the sorted list merge block: list loads, two-head merge, result register.
// Depends on slm_pkg and slm_ram.
`timescale 1ns / 1ps

// Usage:
//  - req channel (req_valid / req_stall): action 0 appends req_value to the first
//    list, action 1 to the second list, action 2 merges, action 3 is ignored.
//    A load into a list that already holds LIST_DEPTH values is dropped.
//  - rsp channel (rsp_valid / rsp_stall): a merge returns every held value of both
//    lists in ascending signed order, one item per value, rsp_last on the final one.
//    On equal values the second list's element goes first. Merging two empty lists
//    returns nothing. After a merge both lists are empty.
//  - Loads are taken one per cycle while idle and return no item.
//  - Merge of N values: req_stall is high after the merge item is taken until the
//    last value is emitted, longer while the receiver stalls a result; the first
//    result is presented once the merge state is entered and the result register
//    loaded, then one per cycle while the receiver keeps rsp_stall low. The rate is
//    set by the two RAM read heads with registered reads, whose next address follows the compare.
//  - rsp_stall freezes the result register and the merge heads; nothing is lost.
//  - Reset (synchronous) empties both lists and drops any pending result. List RAM
//    contents are not cleared; only entries below the fill counts are ever used.
module sorted_list_merge_top #(
   parameter int unsigned LIST_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  slm_pkg::action_type req_action,
   input  slm_pkg::value_type  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output slm_pkg::value_type  rsp_merged_value,
   output logic                rsp_last
);

   import slm_pkg::*;

   localparam int unsigned ADDR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int unsigned CNT_W   = $clog2(LIST_DEPTH + 1);
   localparam int unsigned TOTAL_W = $clog2(2 * LIST_DEPTH + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     first_count_ff, first_count_in;
   logic [CNT_W-1:0]     second_count_ff, second_count_in;
   logic [CNT_W-1:0]     head_a_ff, head_a_in;
   logic [CNT_W-1:0]     head_b_ff, head_b_in;
   logic [TOTAL_W-1:0]   remain_ff, remain_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   value_type            rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_accept;
   logic                 wr_first, wr_second;
   logic [VALUE_W-1:0]   q_a, q_b;
   logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
   logic [CNT_W-1:0]     head_a_next, head_b_next;
   logic                 avail_a, avail_b;
   logic                 take_first;
   logic                 emit_go;
   logic [TOTAL_W-1:0]   total;

   // Input handshake: loads and merge commands only while idle
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign wr_first  = req_accept && (req_action == ACT_APPEND_FIRST)
                      && (first_count_ff < CNT_W'(LIST_DEPTH));
   assign wr_second = req_accept && (req_action == ACT_APPEND_SECOND)
                      && (second_count_ff < CNT_W'(LIST_DEPTH));

   assign total = TOTAL_W'(first_count_ff) + TOTAL_W'(second_count_ff);

   // Merge head selection from the current RAM outputs
   assign avail_a    = head_a_ff < first_count_ff;
   assign avail_b    = head_b_ff < second_count_ff;
   assign take_first = avail_a && (!avail_b || ($signed(q_a) < $signed(q_b)));
   assign emit_go    = (state_ff == ST_MERGE) && (!rsp_valid_ff || !rsp_stall);

   // Read addresses follow the head after this cycle's pick
   assign head_a_next = head_a_ff + CNT_W'(emit_go && take_first);
   assign head_b_next = head_b_ff + CNT_W'(emit_go && !take_first);
   assign rd_addr_a   = head_a_next[ADDR_W-1:0];
   assign rd_addr_b   = head_b_next[ADDR_W-1:0];

   slm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (LIST_DEPTH)
   ) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (first_count_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr_a),
      .rd_data (q_a)
   );

   slm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (LIST_DEPTH)
   ) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (second_count_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr_b),
      .rd_data (q_b)
   );

   // Controller next state
   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      head_a_in       = head_a_ff;
      head_b_in       = head_b_ff;
      remain_in       = remain_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (wr_first) begin
               first_count_in = first_count_ff + 1'b1;
            end
            if (wr_second) begin
               second_count_in = second_count_ff + 1'b1;
            end
            // RAM reads address 0 this cycle, ready for the first compare
            if (req_accept && (req_action == ACT_MERGE) && (total != '0)) begin
               remain_in = total;
               state_in  = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = take_first ? value_type'(q_a) : value_type'(q_b);
               rsp_last_in  = (remain_ff == TOTAL_W'(1));
               head_a_in    = head_a_next;
               head_b_in    = head_b_next;
               remain_in    = remain_ff - 1'b1;
               // Final value: empty both lists and rewind the heads
               if (remain_ff == TOTAL_W'(1)) begin
                  first_count_in  = '0;
                  second_count_in = '0;
                  head_a_in       = '0;
                  head_b_in       = '0;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         head_a_ff       <= '0;
         head_b_ff       <= '0;
         remain_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         head_a_ff       <= head_a_in;
         head_b_ff       <= head_b_in;
         remain_ff       <= remain_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for sorted_list_merge_top: list loads, merges, random idling.
// Depends on slm_pkg and the merge RTL; a scoreboard class predicts every merged run.
`timescale 1ns / 1ps

module tb_top;
   import slm_pkg::*;

   localparam int unsigned LIST_DEPTH  = 16;
   localparam int          QUIET_LIMIT = 2000;
   localparam int          RANDOM_ITEMS = 180;
   // Code 3 has no meaning in the block; it must be ignored
   localparam action_type  ACT_UNUSED  = 2'd3;
   localparam value_type   VALUE_MIN   = 32'sh8000_0000;
   localparam value_type   VALUE_MAX   = 32'sh7FFF_FFFF;

   typedef struct packed {
      value_type merged_value;
      logic      last;
   } merged_result_type;

   // Tracks both lists and the merged runs they should produce
   class merge_scoreboard;
      value_type         first_list[LIST_DEPTH];
      value_type         second_list[LIST_DEPTH];
      int unsigned       first_count;
      int unsigned       second_count;
      merged_result_type expected_q[$];
      int                errors;

      function new();
         first_count  = 0;
         second_count = 0;
         errors       = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Apply one accepted item; a merge queues its whole ascending run
      function void note_request(action_type action, value_type value);
         int unsigned       total, i, j, k;
         bit                take_first;
         merged_result_type item;
         case (action)
            ACT_APPEND_FIRST: begin
               if (first_count < LIST_DEPTH) begin
                  first_list[first_count] = value;
                  first_count++;
               end
            end
            ACT_APPEND_SECOND: begin
               if (second_count < LIST_DEPTH) begin
                  second_list[second_count] = value;
                  second_count++;
               end
            end
            ACT_MERGE: begin
               total = first_count + second_count;
               i = 0;
               j = 0;
               for (k = 0; k < total; k++) begin
                  // ties go to the second list
                  if (i < first_count && j < second_count)
                     take_first = first_list[i] < second_list[j];
                  else
                     take_first = i < first_count;
                  if (take_first) begin
                     item.merged_value = first_list[i];
                     i++;
                  end else begin
                     item.merged_value = second_list[j];
                     j++;
                  end
                  item.last = (k + 1 == total);
                  expected_q.push_back(item);
               end
               first_count  = 0;
               second_count = 0;
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(value_type value, logic last);
         merged_result_type exp_item;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, value %0d last %0b", $time, value, last);
            return;
         end
         exp_item = expected_q.pop_front();
         if (value !== exp_item.merged_value) begin
            errors++;
            $display("%0t: merged_value expected %0d actual %0d",
                     $time, exp_item.merged_value, value);
         end
         if (last !== exp_item.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, exp_item.last, last);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   action_type req_action;
   value_type  req_value;
   logic       rsp_valid;
   logic       rsp_stall;
   value_type  rsp_merged_value;
   logic       rsp_last;

   merge_scoreboard sb = new();
   bit src_calm;
   bit rsp_calm;
   int hold_rsp_cycles;
   int items_sent;
   int quiet_cycles;

   sorted_list_merge_top #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one item after a random gap; note it once accepted
   task automatic send_item(input action_type action, input value_type value);
      int gap;
      gap = src_calm ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid  = 1'b1;
      req_action = action;
      req_value  = value;
      do @(posedge clock); while (req_stall);
      sb.note_request(action, value);
      if (action != ACT_UNUSED)
         items_sent++;
   endtask

   // Withdraw the sender and wait until every merged value has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Random ascending list; narrow values give many ties
   task automatic make_ascending(input int n, input bit narrow,
                                 output value_type vals[LIST_DEPTH + 2]);
      int        a, b;
      value_type t;
      for (a = 0; a < n; a++)
         vals[a] = narrow ? value_type'(int'($urandom_range(0, 8)) - 4)
                          : value_type'($urandom());
      for (a = 1; a < n; a++) begin
         t = vals[a];
         b = a - 1;
         while (b >= 0 && vals[b] > t) begin
            vals[b + 1] = vals[b];
            b--;
         end
         vals[b + 1] = t;
      end
   endtask

   // Load two sorted lists in random interleaving, then merge them
   task automatic run_merge_sequence(input int first_len, input int second_len);
      value_type first_vals[LIST_DEPTH + 2];
      value_type second_vals[LIST_DEPTH + 2];
      bit        narrow;
      int        ia, ib;
      narrow = ($urandom_range(0, 1) == 1);
      make_ascending(first_len, narrow, first_vals);
      make_ascending(second_len, narrow, second_vals);
      ia = 0;
      ib = 0;
      while (ia < first_len || ib < second_len) begin
         if (ib >= second_len || (ia < first_len && $urandom_range(0, 1))) begin
            send_item(ACT_APPEND_FIRST, first_vals[ia]);
            ia++;
         end else begin
            send_item(ACT_APPEND_SECOND, second_vals[ib]);
            ib++;
         end
      end
      send_item(ACT_MERGE, value_type'($urandom()));
   endtask

   // Stimulus: directed cases, then random sequences with pauses
   initial begin : stimulus
      int i, seq, max_len, random_start;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ACT_APPEND_FIRST;
      req_value  = '0;
      src_calm   = 1'b0;
      rsp_calm   = 1'b0;
      hold_rsp_cycles = 0;
      items_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // merge of two empty lists, then an ignored code
      send_item(ACT_MERGE, VALUE_MIN);
      send_item(ACT_UNUSED, VALUE_MAX);
      // extremes in both lists, tied across lists
      send_item(ACT_APPEND_FIRST, VALUE_MIN);
      send_item(ACT_APPEND_SECOND, VALUE_MIN);
      send_item(ACT_APPEND_FIRST, VALUE_MAX);
      send_item(ACT_APPEND_SECOND, VALUE_MAX);
      send_item(ACT_MERGE, '0);
      // one load past a full second list is dropped
      for (i = 0; i < LIST_DEPTH + 1; i++)
         send_item(ACT_APPEND_SECOND, value_type'(i * 3 - 20));
      send_item(ACT_MERGE, '1);

      random_start = items_sent;
      seq = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         src_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         if (seq == 4)
            wait_for_results();
         if (seq == 3) begin
            // receiver holds off while full lists merge and loads keep coming
            src_calm = 1'b1;
            hold_rsp_cycles = 120;
            run_merge_sequence(LIST_DEPTH, LIST_DEPTH);
            run_merge_sequence(3, 3);
         end else if ($urandom_range(0, 7) == 0) begin
            // noise: any code, any value, unsorted loads
            repeat ($urandom_range(3, 8))
               send_item(action_type'($urandom_range(0, 3)), value_type'($urandom()));
         end else begin
            max_len = ($urandom_range(0, 5) == 0) ? LIST_DEPTH + 2 : LIST_DEPTH;
            run_merge_sequence($urandom_range(0, max_len), $urandom_range(0, max_len));
         end
         seq++;
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Result side: random stall before each item, one long hold-off on request
   initial begin : result_sink
      int stall_cycles;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_rsp_cycles > 0) begin
            stall_cycles = hold_rsp_cycles;
            hold_rsp_cycles = 0;
         end else begin
            stall_cycles = rsp_calm ? 0 : $urandom_range(0, 8);
         end
         repeat (stall_cycles) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_merged_value, rsp_last);
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial quiet_cycles = 0;

endmodule

// ===== filelist.f =====
hdl/slm_pkg.sv
hdl/slm_ram.sv
hdl/sorted_list_merge_top.sv
dv/tb_top.sv
